### hdl/itrt_pkg.sv
// Shared types and character constants for the radix text formatter.
package itrt_pkg;

    typedef enum logic [2:0] {
        FMT_BIN  = 3'd0,
        FMT_DEC  = 3'd1,
        FMT_SWAP = 3'd2,
        FMT_HEX  = 3'd3,
        FMT_OCT  = 3'd4
    } fmt_t;

    typedef enum logic [2:0] {
        SER_IDLE,
        SER_PRE0,
        SER_PRE1,
        SER_SIGN,
        SER_DIGIT,
        SER_NL
    } ser_state_t;

    // One item in flight through the pipeline
    typedef struct packed {
        logic [31:0] raw;   // value as received
        logic [31:0] sh;    // binary operand, shifted out by the BCD stages
        logic [39:0] bcd;   // ten BCD digits
        fmt_t        fmt;
        logic        neg;
        logic [4:0]  top;   // index of the leading digit
    } item_t;

    localparam int BCD_DIGITS     = 10;
    localparam int BIN_BITS       = 32;
    localparam int DABBLE_STAGES  = 4;
    localparam int STEPS_PER_STAGE = BIN_BITS / DABBLE_STAGES;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] HEX_GAP    = 8'd39;
    localparam logic [7:0] CHAR_B     = 8'h62;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_O     = 8'h6F;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_NL    = 8'h0A;

endpackage

### hdl/itrt_prep.sv
// Input stage: select the binary operand (negate, byte swap) and drop unused formats.
module itrt_prep (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_value,
    input  logic [2:0]           s_op,
    output logic                 out_valid,
    input  logic                 out_ready,
    output itrt_pkg::item_t      out_item
);
    import itrt_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;
    logic  op_ok;
    fmt_t  fmt;

    assign fmt     = fmt_t'(s_op);
    assign op_ok   = (s_op <= 3'(FMT_OCT));
    assign s_ready = !valid_reg || out_ready;

    always_comb begin
        item_next     = '0;
        item_next.raw = s_value;
        item_next.fmt = fmt;
        item_next.neg = (fmt == FMT_DEC) && s_value[31];
        item_next.sh  = s_value;
        if (item_next.neg) begin
            item_next.sh = 32'd0 - s_value;
        end else if (fmt == FMT_SWAP) begin
            item_next.sh = {s_value[7:0], s_value[15:8], s_value[23:16], s_value[31:24]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            // drop beats with an unused selector: they yield no text
            valid_reg <= s_valid && op_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### hdl/itrt_dabble.sv
// One pipeline stage of shift-and-add-3 binary to BCD conversion.
module itrt_dabble (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  itrt_pkg::item_t      in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output itrt_pkg::item_t      out_item
);
    import itrt_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    always_comb begin
        logic [39:0] b;
        logic [31:0] s;
        b = in_item.bcd;
        s = in_item.sh;
        for (int st = 0; st < STEPS_PER_STAGE; st++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (b[4*d +: 4] >= 4'd5) begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            {b, s} = {b[38:0], s, 1'b0};
        end
        item_next     = in_item;
        item_next.bcd = b;
        item_next.sh  = s;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### hdl/itrt_lead.sv
// Leading digit stage: find the most significant nonzero digit of each format.
module itrt_lead (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  itrt_pkg::item_t      in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output itrt_pkg::item_t      out_item
);
    import itrt_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    always_comb begin
        logic [32:0] oct_ext;
        logic [4:0]  top_bin;
        logic [4:0]  top_hex;
        logic [4:0]  top_oct;
        logic [4:0]  top_dec;
        oct_ext = {1'b0, in_item.raw};
        top_bin = '0;
        top_hex = '0;
        top_oct = '0;
        top_dec = '0;
        for (int i = 0; i < BIN_BITS; i++) begin
            if (in_item.raw[i]) top_bin = 5'(i);
        end
        for (int i = 0; i < 8; i++) begin
            if (in_item.raw[4*i +: 4] != 4'd0) top_hex = 5'(i);
        end
        for (int i = 0; i < 11; i++) begin
            if (oct_ext[3*i +: 3] != 3'd0) top_oct = 5'(i);
        end
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (in_item.bcd[4*i +: 4] != 4'd0) top_dec = 5'(i);
        end
        item_next = in_item;
        case (in_item.fmt)
            FMT_BIN: item_next.top = top_bin;
            FMT_HEX: item_next.top = top_hex;
            FMT_OCT: item_next.top = top_oct;
            default: item_next.top = top_dec;
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### hdl/itrt_serial.sv
// Character sequencer and output register: prefix, sign, digits, newline.
module itrt_serial (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  itrt_pkg::item_t      in_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_char_code,
    output logic                 m_last
);
    import itrt_pkg::*;

    ser_state_t state_reg, state_next;
    item_t      item_reg;
    logic [4:0] pos_reg, pos_next;
    logic       m_valid_reg;
    logic [7:0] m_char_reg, char_next;
    logic       m_last_reg, last_next;
    logic       out_free;
    logic       emit;
    logic       load;
    logic [3:0] digit;
    logic [32:0] oct_ext;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = (state_reg != SER_IDLE) && out_free;
    assign in_ready = (state_reg == SER_IDLE) || ((state_reg == SER_NL) && out_free);
    assign load     = in_valid && in_ready;
    assign oct_ext  = {1'b0, item_reg.raw};

    // pick the digit at the current position
    always_comb begin
        case (item_reg.fmt)
            FMT_BIN: digit = {3'b000, item_reg.raw[pos_reg]};
            FMT_HEX: digit = 4'(item_reg.raw >> {pos_reg[2:0], 2'b00});
            FMT_OCT: digit = {1'b0, 3'(oct_ext >> (6'(pos_reg) * 6'd3))};
            default: digit = 4'(item_reg.bcd >> {pos_reg[3:0], 2'b00});
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        char_next  = CHAR_NL;
        last_next  = 1'b0;
        case (state_reg)
            SER_IDLE: ;
            SER_PRE0: begin
                char_next = CHAR_ZERO;
                if (emit) state_next = SER_PRE1;
            end
            SER_PRE1: begin
                case (item_reg.fmt)
                    FMT_BIN: char_next = CHAR_B;
                    FMT_HEX: char_next = CHAR_X;
                    default: char_next = CHAR_O;
                endcase
                if (emit) state_next = SER_DIGIT;
            end
            SER_SIGN: begin
                char_next = CHAR_MINUS;
                if (emit) state_next = SER_DIGIT;
            end
            SER_DIGIT: begin
                if (digit < 4'd10) begin
                    char_next = CHAR_ZERO + {4'b0000, digit};
                end else begin
                    char_next = CHAR_ZERO + HEX_GAP + {4'b0000, digit};
                end
                if (emit) begin
                    if (pos_reg == 5'd0) begin
                        state_next = SER_NL;
                    end else begin
                        pos_next = pos_reg - 5'd1;
                    end
                end
            end
            SER_NL: begin
                char_next = CHAR_NL;
                last_next = 1'b1;
                if (emit) state_next = SER_IDLE;
            end
            default: state_next = SER_IDLE;
        endcase
        // take the next item right behind the newline
        if (load) begin
            pos_next = in_item.top;
            case (in_item.fmt)
                FMT_BIN, FMT_HEX, FMT_OCT: state_next = SER_PRE0;
                default: state_next = in_item.neg ? SER_SIGN : SER_DIGIT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SER_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_free) begin
                m_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        if (load) begin
            item_reg <= in_item;
        end
        if (out_free) begin
            m_char_reg <= char_next;
            m_last_reg <= last_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last      = m_last_reg;

endmodule

### hdl/integer_to_radix_text_unit.sv
// Top level of the 32-bit integer to ASCII radix text formatter.
// Each input beat (value, op) becomes a run of output beats, one ASCII
// character per beat, ending with a newline that has m_last set. Formats:
// op 0 binary "0b...", 1 signed decimal, 2 unsigned decimal of the
// byte-swapped value, 3 hex "0x...", 4 octal "0o..."; leading zeros are
// dropped but one digit always remains. Op 5 to 7 is accepted and yields
// nothing. An item passes a six-stage pipeline (operand select, four
// binary-to-BCD stages of eight steps each, leading digit search) before
// the character sequencer, which emits one beat per cycle while m_ready
// allows, so an item occupies the output for its text length (2 to 35
// beats). That sequencer sets the sustained rate; up to six further items
// wait in the pipeline meanwhile.
module integer_to_radix_text_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    input  logic [2:0]  s_op,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_code,
    output logic        m_last
);
    import itrt_pkg::*;

    logic  stg_valid [DABBLE_STAGES+1];
    logic  stg_ready [DABBLE_STAGES+1];
    item_t stg_item  [DABBLE_STAGES+1];
    logic  lead_valid;
    logic  lead_ready;
    item_t lead_item;

    itrt_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .s_op      (s_op),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_item  (stg_item[0])
    );

    for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
        itrt_dabble u_dabble (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_item   (stg_item[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    itrt_lead u_lead (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (stg_valid[DABBLE_STAGES]),
        .in_ready  (stg_ready[DABBLE_STAGES]),
        .in_item   (stg_item[DABBLE_STAGES]),
        .out_valid (lead_valid),
        .out_ready (lead_ready),
        .out_item  (lead_item)
    );

    itrt_serial u_serial (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (lead_valid),
        .in_ready    (lead_ready),
        .in_item     (lead_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

    // The closing beat is always the newline, and only it is
    a_last_is_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_char_code == CHAR_NL)))
        else $error("last flag and newline character disagree");

    // Leading digit index stays inside the digit count of its format
    a_lead_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        lead_valid |->
            ((lead_item.fmt == FMT_HEX && lead_item.top <= 5'd7) ||
             (lead_item.fmt == FMT_OCT && lead_item.top <= 5'd10) ||
             (lead_item.fmt == FMT_DEC && lead_item.top <= 5'd9) ||
             (lead_item.fmt == FMT_SWAP && lead_item.top <= 5'd9) ||
             lead_item.fmt == FMT_BIN))
        else $error("leading digit index out of range");

    // Decimal conversion leaves the top BCD digit at most four and the lowest at most nine
    a_bcd_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        lead_valid |-> (lead_item.bcd[39:36] <= 4'd4 && lead_item.bcd[3:0] <= 4'd9))
        else $error("invalid BCD digit after conversion");

endmodule
